// ===== rtl/att_pkg.sv =====
// Shared types, widths and constants of the adaptive tempo tracker.
package att_pkg;

    // Field and register widths
    localparam int TIMER_W    = 48;
    localparam int DELTA_W    = 16;
    localparam int MULT_W     = 32;
    localparam int TEMPO_W    = 10;
    localparam int RATE_W     = 18;
    localparam int HLEN_W     = 4;
    localparam int MODE_W     = 2;
    localparam int FUNC_W     = 2;
    localparam int COUNT_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    // Fraction bits of the Q16.16 multiplier, also the delta quotient width
    localparam int FRAC_W = 16;
    // Sample count times 1000 needs at most 10 extra bits
    localparam int MS_SCALE_W = 10;

    // Shared divider
    localparam int QUO_W     = 32;
    localparam int DIV_CNT_W = 6;

    localparam int DEFAULT_HISTORY_DEPTH = 10;
    localparam int MS_PER_MIN            = 60000;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMPO = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HLEN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WMIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_WMAX  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE  = 3'd5;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_BETWEEN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUSTAIN = 2'd2;

    // Reset values
    localparam logic [MODE_W-1:0]  RST_MODE  = 2'd0;
    localparam logic [TEMPO_W-1:0] RST_TEMPO = 10'd120;
    localparam logic [HLEN_W-1:0]  RST_HLEN  = 4'd4;
    localparam logic [DELTA_W-1:0] RST_WMIN  = 16'd0;
    localparam logic [DELTA_W-1:0] RST_WMAX  = 16'd12000;
    localparam logic [RATE_W-1:0]  RST_RATE  = 18'd48000;
    localparam logic [DELTA_W-1:0] HIST_RESET = 16'd500;
    localparam logic [MULT_W-1:0]  MULT_ONE   = 32'h0001_0000;
    localparam logic [MULT_W-1:0]  MULT_MAX   = 32'hFFFF_FFFF;
    localparam logic [DELTA_W-1:0] DELTA_MAX  = 16'hFFFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADVANCE  = 2'd0,
        FUNC_NOTE_ON  = 2'd1,
        FUNC_NOTE_OFF = 2'd2,
        FUNC_RESET    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        DIV_DELTA = 2'd0,
        DIV_MULT  = 2'd1,
        DIV_FILL  = 2'd2
    } div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     item_load;
        logic     timer_add;
        logic     onset_load;
        logic     diff_load;
        logic     nprod_load;
        logic     div_start;
        div_sel_t div_sel;
        logic     delta_sat;
        logic     delta_load;
        logic     ring_write;
        logic     sum_step;
        logic     mprod_load;
        logic     mult_sat;
        logic     mult_load;
        logic     fill;
        logic     out_load;
        logic     out_upd;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        func_t             func;
        logic              hist_zero;
        logic              delta_over;
        logic              window_ok;
        logic              sum_done;
        logic              mult_over;
        logic              div_done;
    } sts_t;

endpackage

// ===== rtl/att_div.sv =====
// Restoring divider, one quotient bit per cycle.
module att_div import att_pkg::*; #(
    parameter int DW = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        divisor,
    input  logic [DW-1:0]        rem_init,   // must be below divisor
    input  logic [QUO_W-1:0]     num_lo,     // dividend bits, shifted in MSB first
    input  logic [DIV_CNT_W-1:0] nbits,
    output logic                 busy,
    output logic                 done,
    output logic [QUO_W-1:0]     quo
);

    logic [DW-1:0]        d_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        rem_next;
    logic [QUO_W-1:0]     lo_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DW:0]          shifted;
    logic [DW:0]          trial;
    logic                 qbit;

    always_comb
    begin
        shifted  = {rem_reg, lo_reg[QUO_W-1]};
        trial    = shifted - {1'b0, d_reg};
        qbit     = shifted >= {1'b0, d_reg};
        rem_next = qbit ? trial[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor;
            rem_reg <= rem_init;
            lo_reg  <= num_lo;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/att_dp.sv =====
// Datapath: configuration, timer, interval ring, accumulator, divider, result register.
module att_dp import att_pkg::*; #(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0]     in_func,
    input  logic [COUNT_W-1:0]    in_count,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic [MULT_W-1:0]     out_mult,
    output logic [DELTA_W-1:0]    out_delta,
    output logic                  out_upd
);

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int N_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = DELTA_W + N_W;
    localparam int PROD_W = SUM_W + TEMPO_W;
    localparam int DEN_W  = $clog2(HISTORY_DEPTH * MS_PER_MIN + 1);
    localparam int DW     = (DEN_W > RATE_W) ? DEN_W : RATE_W;
    localparam int NUM_W  = TIMER_W + MS_SCALE_W;
    localparam int CMP_W  = (PROD_W > DEN_W + FRAC_W) ? PROD_W : DEN_W + FRAC_W;

    // configuration
    logic [MODE_W-1:0]  mode_reg;
    logic [TEMPO_W-1:0] tempo_reg;
    logic [HLEN_W-1:0]  hlen_reg;
    logic [DELTA_W-1:0] wmin_reg;
    logic [DELTA_W-1:0] wmax_reg;
    logic [RATE_W-1:0]  rate_reg;

    // item and state
    func_t              func_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] onset_reg;
    logic [TIMER_W-1:0] diff_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   num_next;
    logic [DELTA_W-1:0] delta_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic [DELTA_W-1:0] ring_reg [HISTORY_DEPTH];
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [N_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DEN_W-1:0]   den_reg;

    logic [TEMPO_W-1:0]   eff_tempo;
    logic [RATE_W-1:0]    eff_rate;
    logic [N_W-1:0]       n_eff;
    logic [IDX_W-1:0]     idx_inc;
    logic [IDX_W-1:0]     ptr_dec;
    logic [PROD_W+DW-1:0] prod_ext;

    // divider operands
    logic [DW-1:0]        div_d;
    logic [DW-1:0]        div_rem;
    logic [QUO_W-1:0]     div_lo;
    logic [DIV_CNT_W-1:0] div_nbits;
    logic                 div_busy;
    logic                 div_done;
    logic [QUO_W-1:0]     div_quo;

    // payload of the result register
    logic [MULT_W-1:0]  out_mult_reg;
    logic [DELTA_W-1:0] out_delta_reg;
    logic               out_upd_reg;

    always_comb
    begin
        eff_tempo = (tempo_reg == '0) ? TEMPO_W'(1) : tempo_reg;
        eff_rate  = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
        n_eff     = (32'(hlen_reg) > HISTORY_DEPTH) ? N_W'(HISTORY_DEPTH) : N_W'(hlen_reg);
        idx_inc   = (idx_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
        ptr_dec   = (ptr_reg == '0) ? IDX_W'(HISTORY_DEPTH - 1) : ptr_reg - 1'b1;
        // diff * 1000 as diff * (1024 - 16 - 8)
        num_next  = {diff_reg, 10'b0} - NUM_W'({diff_reg, 4'b0}) - NUM_W'({diff_reg, 3'b0});
        prod_ext  = (PROD_W + DW)'(prod_reg);
    end

    always_comb
    begin
        div_d     = '0;
        div_rem   = '0;
        div_lo    = '0;
        div_nbits = '0;
        unique case (cmd.div_sel)
            DIV_DELTA:
            begin
                div_d     = DW'(eff_rate);
                div_rem   = num_reg[FRAC_W +: DW];
                div_lo    = {num_reg[FRAC_W-1:0], FRAC_W'(0)};
                div_nbits = DIV_CNT_W'(FRAC_W);
            end
            DIV_MULT:
            begin
                div_d     = DW'(den_reg);
                div_rem   = prod_ext[FRAC_W +: DW];
                div_lo    = {prod_reg[FRAC_W-1:0], FRAC_W'(0)};
                div_nbits = DIV_CNT_W'(QUO_W);
            end
            DIV_FILL:
            begin
                div_d     = DW'(eff_tempo);
                div_lo    = {FRAC_W'(MS_PER_MIN), FRAC_W'(0)};
                div_nbits = DIV_CNT_W'(FRAC_W);
            end
            default:
            begin
                div_d = '0;
            end
        endcase
    end

    att_div #(
        .DW(DW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .divisor (div_d),
        .rem_init(div_rem),
        .num_lo  (div_lo),
        .nbits   (div_nbits),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= RST_MODE;
            tempo_reg <= RST_TEMPO;
            hlen_reg  <= RST_HLEN;
            wmin_reg  <= RST_WMIN;
            wmax_reg  <= RST_WMAX;
            rate_reg  <= RST_RATE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_TEMPO: tempo_reg <= cfg_data[TEMPO_W-1:0];
                CFG_HLEN:  hlen_reg  <= cfg_data[HLEN_W-1:0];
                CFG_WMIN:  wmin_reg  <= cfg_data[DELTA_W-1:0];
                CFG_WMAX:  wmax_reg  <= cfg_data[DELTA_W-1:0];
                CFG_RATE:  rate_reg  <= cfg_data[RATE_W-1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            onset_reg <= '0;
            delta_reg <= '0;
            mult_reg  <= MULT_ONE;
            idx_reg   <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                ring_reg[i] <= HIST_RESET;
            end
        end
        else
        begin
            if (cmd.timer_add)
            begin
                timer_reg <= timer_reg + TIMER_W'(count_reg);
            end
            if (cmd.onset_load)
            begin
                onset_reg <= timer_reg;
            end
            if (cmd.delta_sat)
            begin
                delta_reg <= DELTA_MAX;
            end
            else if (cmd.delta_load)
            begin
                delta_reg <= div_quo[DELTA_W-1:0];
            end
            if (cmd.mult_sat)
            begin
                mult_reg <= MULT_MAX;
            end
            else if (cmd.mult_load)
            begin
                mult_reg <= div_quo;
            end
            else if (cmd.fill)
            begin
                mult_reg <= MULT_ONE;
            end
            if (cmd.fill)
            begin
                idx_reg <= '0;
                for (int i = 0; i < HISTORY_DEPTH; i++)
                begin
                    ring_reg[i] <= div_quo[DELTA_W-1:0];
                end
            end
            else if (cmd.ring_write)
            begin
                ring_reg[idx_reg] <= delta_reg;
                idx_reg           <= idx_inc;
            end
        end
    end

    // working registers of one item
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            func_reg  <= func_t'(in_func);
            count_reg <= in_count;
        end
        if (cmd.diff_load)
        begin
            diff_reg <= timer_reg - onset_reg;
        end
        if (cmd.nprod_load)
        begin
            num_reg <= num_next;
        end
        if (cmd.ring_write)
        begin
            // walk back from the new write position
            ptr_reg <= idx_inc;
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            ptr_reg <= ptr_dec;
            cnt_reg <= cnt_reg + 1'b1;
            sum_reg <= sum_reg + SUM_W'(ring_reg[ptr_dec]);
        end
        if (cmd.mprod_load)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(eff_tempo);
            den_reg  <= DEN_W'(n_eff * MS_PER_MIN);
        end
        if (cmd.out_load)
        begin
            out_mult_reg  <= mult_reg;
            out_delta_reg <= delta_reg;
            out_upd_reg   <= cmd.out_upd;
        end
    end

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.func       = func_reg;
        sts.hist_zero  = (hlen_reg == '0);
        sts.delta_over = num_reg >= NUM_W'({eff_rate, FRAC_W'(0)});
        sts.window_ok  = (delta_reg > wmin_reg) && (delta_reg < wmax_reg);
        sts.sum_done   = (cnt_reg == n_eff);
        sts.mult_over  = CMP_W'(prod_reg) >= CMP_W'({den_reg, FRAC_W'(0)});
        sts.div_done   = div_done;
    end

    assign out_mult  = out_mult_reg;
    assign out_delta = out_delta_reg;
    assign out_upd   = out_upd_reg;

`ifndef ASSERT_OFF
    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(idx_reg) < HISTORY_DEPTH)
        else $error("write index out of range");

    a_ring_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ring_write |-> sts.window_ok)
        else $error("ring written with interval outside window");

    a_fill_restores: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |=> (mult_reg == MULT_ONE) && (idx_reg == '0))
        else $error("reset item did not restore multiplier and index");

    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_step |-> !sts.sum_done)
        else $error("accumulator stepped past history length");
`endif

endmodule

// ===== rtl/att_ctrl.sv =====
// Controller: sequences one item at a time through the datapath.
module att_ctrl import att_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIFF,
        S_NPROD,
        S_DCHK,
        S_DDIV,
        S_WIN,
        S_SUM,
        S_MPROD,
        S_MCHK,
        S_MDIV,
        S_MEND,
        S_FDIV,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   upd_reg;
    logic   active;

    assign active = (sts.mode == MODE_BETWEEN) || (sts.mode == MODE_SUSTAIN);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!active)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    unique case (sts.func)
                        FUNC_ADVANCE:
                        begin
                            cmd.timer_add = 1'b1;
                            state_next    = S_FINISH;
                        end
                        FUNC_NOTE_ON:
                        begin
                            if (sts.mode == MODE_BETWEEN && !sts.hist_zero)
                            begin
                                state_next = S_DIFF;
                            end
                            else
                            begin
                                cmd.onset_load = 1'b1;
                                state_next     = S_FINISH;
                            end
                        end
                        FUNC_NOTE_OFF:
                        begin
                            if (sts.mode == MODE_SUSTAIN && !sts.hist_zero)
                            begin
                                state_next = S_DIFF;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        FUNC_RESET:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_FILL;
                            state_next    = S_FDIV;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = S_NPROD;
            end
            S_NPROD:
            begin
                cmd.nprod_load = 1'b1;
                state_next     = S_DCHK;
            end
            S_DCHK:
            begin
                if (sts.delta_over)
                begin
                    cmd.delta_sat = 1'b1;
                    state_next    = S_WIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DELTA;
                    state_next    = S_DDIV;
                end
            end
            S_DDIV:
            begin
                cmd.div_sel = DIV_DELTA;
                if (sts.div_done)
                begin
                    cmd.delta_load = 1'b1;
                    state_next     = S_WIN;
                end
            end
            S_WIN:
            begin
                if (sts.window_ok)
                begin
                    cmd.ring_write = 1'b1;
                    state_next     = S_SUM;
                end
                else
                begin
                    state_next = S_MEND;
                end
            end
            S_SUM:
            begin
                if (!sts.sum_done)
                begin
                    cmd.sum_step = 1'b1;
                end
                else
                begin
                    state_next = S_MPROD;
                end
            end
            S_MPROD:
            begin
                cmd.mprod_load = 1'b1;
                state_next     = S_MCHK;
            end
            S_MCHK:
            begin
                if (sts.mult_over)
                begin
                    cmd.mult_sat = 1'b1;
                    state_next   = S_MEND;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MULT;
                    state_next    = S_MDIV;
                end
            end
            S_MDIV:
            begin
                cmd.div_sel = DIV_MULT;
                if (sts.div_done)
                begin
                    cmd.mult_load = 1'b1;
                    state_next    = S_MEND;
                end
            end
            S_MEND:
            begin
                // a note-on records its onset after measuring
                cmd.onset_load = (sts.func == FUNC_NOTE_ON);
                state_next     = S_FINISH;
            end
            S_FDIV:
            begin
                cmd.div_sel = DIV_FILL;
                if (sts.div_done)
                begin
                    cmd.fill   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_upd  = upd_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.item_load)
            begin
                upd_reg <= 1'b0;
            end
            else if (cmd.ring_write)
            begin
                upd_reg <= 1'b1;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/adaptive_tempo_tracker.sv =====
// Top level of the adaptive tempo tracker: controller, datapath and ports.
// Input to output transfer: time-advance, ignored and non-measuring items go straight to the
//   result; a reset item and a measured note event wait on the one-bit-per-cycle shared
//   divider, and a note event that enters the history also sums its averaged entries.
// Throughput: one item at a time; the next input is taken once the result is in the output
//   register. Reset: rst_n async, active low; defaults, timer and onset 0, history 500, 1.0.
module adaptive_tempo_tracker import att_pkg::*; #(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] sample_count
    input  logic [1:0]            s_axis_tuser,   // [1:0] func

    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,   // [31:0] period_multiplier, [47:32] last_delta_ms
    output logic [0:0]            m_axis_tuser    // [0] updated
);

    cmd_t               cmd;
    sts_t               sts;
    logic [MULT_W-1:0]  out_mult;
    logic [DELTA_W-1:0] out_delta;
    logic               out_upd;

    // Sequencer: accepts a transfer in idle, walks the measurement steps,
    // and parks the result in the output register.
    att_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Timer, onset time, interval ring, running sum and shared divider.
    att_dp #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_func  (s_axis_tuser[FUNC_W-1:0]),
        .in_count (s_axis_tdata[COUNT_W-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .out_mult (out_mult),
        .out_delta(out_delta),
        .out_upd  (out_upd)
    );

    assign m_axis_tdata = {out_delta, out_mult};
    assign m_axis_tuser = out_upd;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the adaptive tempo tracker.
module testbench;
    import att_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode codes the package leaves unnamed: both leave the tracker idle
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int RING_DEPTH    = DEFAULT_HISTORY_DEPTH;
    localparam int RANDOM_ITEMS  = 1650;     // tracked items before the quiet finish
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SPAN_CAP      = 600000;   // longest note interval, in samples
    localparam int LONG_HOLD     = 250;      // receiver hold-off, in cycles

    typedef struct packed {
        logic [MULT_W-1:0]  multiplier;
        logic [DELTA_W-1:0] delta_ms;
        logic               updated;
    } tempo_result_t;

    // ---------------------------------------------------------------
    // Clock, reset and the block's ports
    // ---------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;   // [15:0] sample_count
    logic [1:0]            s_axis_tuser  = '0;   // [1:0] func

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;         // [31:0] period_multiplier, [47:32] last_delta_ms
    logic [0:0]            m_axis_tuser;         // [0] updated

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    adaptive_tempo_tracker u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the configuration and of the tracker state
    // ---------------------------------------------------------------
    logic [MODE_W-1:0]  cfg_mode;
    logic [TEMPO_W-1:0] cfg_tempo;
    logic [HLEN_W-1:0]  cfg_hist_len;
    logic [DELTA_W-1:0] cfg_win_min;
    logic [DELTA_W-1:0] cfg_win_max;
    logic [RATE_W-1:0]  cfg_rate;

    logic [TIMER_W-1:0] timer_samples;
    logic [TIMER_W-1:0] onset_samples;
    logic [DELTA_W-1:0] interval_ring [RING_DEPTH];
    int unsigned        ring_ptr;
    logic [MULT_W-1:0]  multiplier;
    logic [DELTA_W-1:0] last_ms;

    tempo_result_t tempo_results_q[$];   // expected results, oldest first

    int unsigned mismatches    = 0;
    int unsigned tracked_items = 0;      // items taken while adapting
    int unsigned cycle_count   = 0;
    bit          src_idle_en   = 1'b1;
    bit          rx_idle_en    = 1'b1;
    int unsigned rx_hold       = 0;      // long receiver hold-off request

    function automatic logic [63:0] tempo_eff();
        return {54'd0, (cfg_tempo == '0) ? 10'd1 : cfg_tempo};
    endfunction

    function automatic void refill_ring();
        logic [63:0] beat_ms;
        beat_ms = 64'd60000 / tempo_eff();
        for (int i = 0; i < RING_DEPTH; i++)
            interval_ring[i] = beat_ms[DELTA_W-1:0];
        ring_ptr   = 0;
        multiplier = MULT_ONE;
    endfunction

    function automatic void load_power_on_state();
        cfg_mode      = RST_MODE;
        cfg_tempo     = RST_TEMPO;
        cfg_hist_len  = RST_HLEN;
        cfg_win_min   = RST_WMIN;
        cfg_win_max   = RST_WMAX;
        cfg_rate      = RST_RATE;
        timer_samples = '0;
        onset_samples = '0;
        last_ms       = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            interval_ring[i] = HIST_RESET;
        ring_ptr   = 0;
        multiplier = MULT_ONE;
    endfunction

    // Measure the interval since the last onset; returns 1 when it entered the ring.
    function automatic logic log_interval();
        logic [TIMER_W-1:0] span;
        logic [63:0]        ms;
        logic [63:0]        total;
        logic [63:0]        quo;
        int unsigned        n;
        int unsigned        slot;
        int                 i;
        if (cfg_hist_len == '0)
            return 1'b0;
        span    = timer_samples - onset_samples;
        ms      = ({16'd0, span} * 64'd1000) / {46'd0, (cfg_rate == '0) ? 18'd1 : cfg_rate};
        last_ms = (ms > 64'd65535) ? DELTA_MAX : ms[DELTA_W-1:0];
        if (!(last_ms > cfg_win_min && last_ms < cfg_win_max))
            return 1'b0;
        interval_ring[ring_ptr] = last_ms;
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        n        = (cfg_hist_len > RING_DEPTH) ? RING_DEPTH : cfg_hist_len;
        total    = '0;
        slot     = ring_ptr;
        for (i = 0; i < n; i++)
        begin
            slot  = (slot + RING_DEPTH - 1) % RING_DEPTH;
            total = total + interval_ring[slot];
        end
        quo = (total * tempo_eff() * 64'd65536) / (64'(n) * 64'd60000);
        multiplier = (quo > 64'hFFFF_FFFF) ? MULT_MAX : quo[MULT_W-1:0];
        return 1'b1;
    endfunction

    // Advance the shadow state by one item and give the result it must produce.
    function automatic tempo_result_t track_tempo(input func_t func, input logic [15:0] count);
        tempo_result_t res;
        logic          took;
        took = 1'b0;
        if (cfg_mode == MODE_BETWEEN || cfg_mode == MODE_SUSTAIN)
        begin
            case (func)
                FUNC_ADVANCE:  timer_samples = timer_samples + TIMER_W'(count);
                FUNC_NOTE_ON:
                begin
                    if (cfg_mode == MODE_BETWEEN)
                        took = log_interval();
                    onset_samples = timer_samples;
                end
                FUNC_NOTE_OFF:
                begin
                    if (cfg_mode == MODE_SUSTAIN)
                        took = log_interval();
                end
                default:       refill_ring();
            endcase
        end
        res.multiplier = multiplier;
        res.delta_ms   = last_ms;
        res.updated    = took;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers; every task starts and ends at a falling edge
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_MODE:  cfg_mode     = value[MODE_W-1:0];
            CFG_TEMPO: cfg_tempo    = value[TEMPO_W-1:0];
            CFG_HLEN:  cfg_hist_len = value[HLEN_W-1:0];
            CFG_WMIN:  cfg_win_min  = value[DELTA_W-1:0];
            CFG_WMAX:  cfg_win_max  = value[DELTA_W-1:0];
            CFG_RATE:  cfg_rate     = value[RATE_W-1:0];
            default:   ;
        endcase
    endtask

    task automatic write_all(input logic [MODE_W-1:0] mode, input int unsigned tempo,
                             input int unsigned hlen, input int unsigned wmin,
                             input int unsigned wmax, input int unsigned rate);
        write_reg(CFG_MODE,  CFG_DATA_W'(mode));
        write_reg(CFG_TEMPO, CFG_DATA_W'(tempo));
        write_reg(CFG_HLEN,  CFG_DATA_W'(hlen));
        write_reg(CFG_WMIN,  CFG_DATA_W'(wmin));
        write_reg(CFG_WMAX,  CFG_DATA_W'(wmax));
        write_reg(CFG_RATE,  CFG_DATA_W'(rate));
    endtask

    // One input transfer; valid stays high afterwards so items can go back to back.
    task automatic send_item(input func_t func, input logic [15:0] count);
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= count;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cfg_mode == MODE_BETWEEN || cfg_mode == MODE_SUSTAIN)
            tracked_items++;
        tempo_results_q.push_back(track_tempo(func, count));
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has been seen.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tempo_results_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_noise();
        send_item(func_t'($urandom_range(0, 3)), 16'($urandom));
    endtask

    // Split a span of samples into advance items of random size.
    task automatic advance_by(input int unsigned span);
        int unsigned chunk;
        while (span > 0)
        begin
            chunk = $urandom_range(1, 65535);
            if (chunk > span)
                chunk = span;
            send_item(FUNC_ADVANCE, 16'(chunk));
            span -= chunk;
        end
    endtask

    // Well-formed note sequence with intervals aimed mostly inside the window.
    task automatic play_phrase(input int unsigned notes);
        int unsigned rate_eff;
        int unsigned lo;
        int unsigned hi;
        int unsigned target;
        logic [63:0] span;
        rate_eff = (cfg_rate == '0) ? 1 : cfg_rate;
        repeat (notes)
        begin
            if ($urandom_range(0, 11) == 0)
                send_noise();
            if ($urandom_range(0, 24) == 0)
                send_item(FUNC_RESET, 16'($urandom));
            send_item(FUNC_NOTE_ON, 16'($urandom));
            if (cfg_win_max > cfg_win_min + 1 && $urandom_range(0, 4) != 0)
            begin
                lo = cfg_win_min + 1;
                hi = cfg_win_max - 1;
                if (hi - lo > 3000)
                    hi = lo + 3000;
                target = $urandom_range(lo, hi);
            end
            else
                target = $urandom_range(0, 20000);
            span = (64'(target) * rate_eff) / 1000 + $urandom_range(0, rate_eff / 1000);
            if (span > SPAN_CAP)
                span = SPAN_CAP;
            if (cfg_mode == MODE_SUSTAIN)
            begin
                advance_by(span[31:0]);
                send_item(FUNC_NOTE_OFF, 16'($urandom));
                advance_by($urandom_range(0, 30000));
            end
            else
            begin
                // a note-off in the middle must not disturb between-notes timing
                if ($urandom_range(0, 3) == 0)
                    send_item(FUNC_NOTE_OFF, 16'($urandom));
                advance_by(span[31:0]);
            end
        end
    endtask

    task automatic pick_settings();
        int unsigned pick;
        int unsigned rates[5] = '{8000, 44100, 48000, 96000, 192000};
        logic [MODE_W-1:0] mode;
        int unsigned tempo;
        int unsigned wmin;
        int unsigned wmax;
        int unsigned rate;
        pick = $urandom_range(0, 11);
        mode = (pick == 0) ? MODE_OFF : (pick == 1) ? MODE_SPARE :
               (pick[0] ? MODE_BETWEEN : MODE_SUSTAIN);
        pick = $urandom_range(0, 9);
        tempo = (pick == 0) ? 0 : (pick == 1) ? 1023 : (pick == 2) ? 1 :
                (pick == 3) ? $urandom_range(0, 1023) : $urandom_range(40, 300);
        pick = $urandom_range(0, 9);
        wmin = (pick == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
        pick = $urandom_range(0, 9);
        wmax = (pick == 0) ? 65535 : (pick == 1) ? $urandom_range(0, 65535) :
               $urandom_range(1000, 12000);
        pick = $urandom_range(0, 9);
        rate = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(0, 262143) :
               rates[$urandom_range(0, 4)];
        write_all(mode, tempo, $urandom_range(0, 15), wmin, wmax, rate);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Result check: every transfer against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        tempo_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tempo_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = tempo_results_q.pop_front();
                if (m_axis_tdata[31:0] !== want.multiplier)
                begin
                    $display("%0t: period_multiplier expected %h, got %h",
                             $time, want.multiplier, m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (m_axis_tdata[47:32] !== want.delta_ms)
                begin
                    $display("%0t: last_delta_ms expected %0d, got %0d",
                             $time, want.delta_ms, m_axis_tdata[47:32]);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.updated)
                begin
                    $display("%0t: updated expected %b, got %b",
                             $time, want.updated, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, tempo_results_q.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Modes 0 and 3: every item, time advance and reset included, leaves state alone.
    task automatic test_ignored_modes();
        send_item(FUNC_ADVANCE, 16'hFFFF);
        send_item(FUNC_NOTE_ON, 16'h0000);
        send_item(FUNC_NOTE_OFF, 16'hFFFF);
        send_item(FUNC_RESET, 16'h5A5A);
        settle();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_SPARE));
        send_item(FUNC_ADVANCE, 16'h0000);
        send_item(FUNC_NOTE_ON, 16'hA5A5);
        settle();
    endtask

    // Between-notes mode: in-window interval, note-off ignored, saturation, reset item.
    task automatic test_between_notes();
        write_all(MODE_BETWEEN, RST_TEMPO, RST_HLEN, RST_WMIN, RST_WMAX, RST_RATE);
        send_item(FUNC_NOTE_ON, 16'd0);       // zero interval sits on the window floor
        send_item(FUNC_ADVANCE, 16'd24000);
        send_item(FUNC_NOTE_OFF, 16'd0);
        send_item(FUNC_NOTE_ON, 16'd0);       // 500 ms
        send_item(FUNC_ADVANCE, 16'd36000);
        send_item(FUNC_NOTE_ON, 16'd0);       // 750 ms
        settle();
        // zero sample rate counts as 1 Hz: 100 samples saturate the delta
        write_reg(CFG_RATE, '0);
        send_item(FUNC_ADVANCE, 16'd100);
        send_item(FUNC_NOTE_ON, 16'd0);
        send_item(FUNC_RESET, 16'd0);
        settle();
    endtask

    // Sustain mode with the register extremes.
    task automatic test_sustain_extremes();
        write_all(MODE_SUSTAIN, 1023, 15, 0, 65535, 262143);
        send_item(FUNC_NOTE_ON, 16'd0);
        send_item(FUNC_ADVANCE, 16'hFFFF);
        send_item(FUNC_NOTE_OFF, 16'd0);      // long history clamps to the ring depth
        send_item(FUNC_NOTE_OFF, 16'd0);
        send_item(FUNC_NOTE_ON, 16'd0);       // onset only, no measurement
        settle();
        write_reg(CFG_WMIN, CFG_DATA_W'(65535)); // empty window
        send_item(FUNC_ADVANCE, 16'd5000);
        send_item(FUNC_NOTE_OFF, 16'd0);
        settle();
        write_reg(CFG_HLEN, '0);                 // history length zero: no measurement
        write_reg(CFG_TEMPO, '0);                // zero tempo counts as 1 bpm
        send_item(FUNC_NOTE_OFF, 16'd0);
        send_item(FUNC_RESET, 16'd0);
        settle();
    endtask

    // Receiver holds off long enough to back the block up onto its input.
    task automatic test_output_backpressure();
        write_all(MODE_BETWEEN, 90, 6, 10, 20000, 48000);
        rx_hold = LONG_HOLD;
        repeat (8)
        begin
            send_item(FUNC_ADVANCE, 16'($urandom_range(20000, 40000)));
            send_item(FUNC_NOTE_ON, 16'($urandom));
        end
        settle();
    endtask

    task automatic test_random_traffic();
        while (tracked_items < RANDOM_ITEMS)
        begin
            pick_settings();
            if (cfg_mode == MODE_BETWEEN || cfg_mode == MODE_SUSTAIN)
                play_phrase($urandom_range(4, 24));
            else
                repeat ($urandom_range(3, 10)) send_noise();
            settle();
        end
    endtask

    // Full-rate tail: no idling on either side.
    task automatic test_quiet_finish();
        src_idle_en = 1'b0;
        rx_idle_en  = 1'b0;
        pick_settings();
        write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 1) ? MODE_BETWEEN : MODE_SUSTAIN));
        play_phrase(12);
        settle();
    endtask

    initial
    begin
        load_power_on_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_ignored_modes();
        test_between_notes();
        test_sustain_extremes();
        test_output_backpressure();
        test_random_traffic();
        test_quiet_finish();

        // let any stray result show up before the verdict
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/att_pkg.sv
rtl/att_div.sv
rtl/att_dp.sv
rtl/att_ctrl.sv
rtl/adaptive_tempo_tracker.sv
dv/testbench.sv
